/* sv/srmj_pkg.sv */
// Shared codes and constants for the sorted record merge join unit.
// No dependencies; used by srmj_core, srmj_out_reg and the top level.
`timescale 1ns / 1ps

package srmj_pkg;

  // Running row counters are fixed width and saturate at all ones
  localparam int COUNT_BITS = 32;

  // Row kind codes
  typedef logic [1:0] row_kind_t;
  localparam row_kind_t KIND_FIRST  = 2'd0;
  localparam row_kind_t KIND_SECOND = 2'd1;
  localparam row_kind_t KIND_BOTH   = 2'd2;

  // Side request codes
  typedef logic [1:0] need_side_t;
  localparam need_side_t NEED_FIRST    = 2'd0;
  localparam need_side_t NEED_SECOND   = 2'd1;
  localparam need_side_t NEED_EITHER   = 2'd2;
  localparam need_side_t NEED_FINISHED = 2'd3;

  // Per-side head status
  typedef struct packed {
    logic head_valid;
    logic finished;
  } side_status_t;

  // Compute which side the producer should send next
  function automatic need_side_t wanted_side(side_status_t first, side_status_t second);
    need_side_t need;
    if (!first.head_valid && !second.head_valid && first.finished && second.finished) begin
      need = NEED_FINISHED;
    end else if (!first.head_valid && !first.finished &&
                 !second.head_valid && !second.finished) begin
      need = NEED_EITHER;
    end else if (!first.head_valid && !first.finished) begin
      need = NEED_FIRST;
    end else if (!second.head_valid && !second.finished) begin
      need = NEED_SECOND;
    end else begin
      need = NEED_FINISHED;
    end
    return need;
  endfunction

  // Saturating increment of a row counter
  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

/* sv/srmj_core.sv */
// Head registers, end flags, key compare and row counters of the merge join.
// Depends on srmj_pkg; produces the next result beat for srmj_out_reg.
`timescale 1ns / 1ps

module srmj_core #(
  parameter int CHROM_BITS = 8,
  parameter int LOCUS_BITS = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                side_i,
  input  logic                                end_of_side_i,
  input  logic [CHROM_BITS-1:0]               chrom_i,
  input  logic [LOCUS_BITS-1:0]               locus_i,
  input  logic [VALUE_BITS-1:0]               read_value_i,
  output logic                                row_valid_o,
  output logic [CHROM_BITS-1:0]               row_chrom_o,
  output logic [LOCUS_BITS-1:0]               row_locus_o,
  output logic [VALUE_BITS-1:0]               row_first_value_o,
  output logic [VALUE_BITS-1:0]               row_second_value_o,
  output srmj_pkg::row_kind_t                 row_kind_o,
  output logic [srmj_pkg::COUNT_BITS-1:0]     total_rows_o,
  output logic [srmj_pkg::COUNT_BITS-1:0]     first_only_rows_o,
  output logic [srmj_pkg::COUNT_BITS-1:0]     second_only_rows_o,
  output logic [srmj_pkg::COUNT_BITS-1:0]     matched_rows_o,
  output srmj_pkg::need_side_t                need_side_o
);

  localparam int KEY_BITS = CHROM_BITS + LOCUS_BITS;

  srmj_pkg::side_status_t first_q, first_d, second_q, second_d;
  srmj_pkg::side_status_t first_ld, second_ld;
  logic [CHROM_BITS-1:0] first_chrom_q, first_chrom_d, second_chrom_q, second_chrom_d;
  logic [LOCUS_BITS-1:0] first_locus_q, first_locus_d, second_locus_q, second_locus_d;
  logic [VALUE_BITS-1:0] first_value_q, first_value_d, second_value_q, second_value_d;
  logic [srmj_pkg::COUNT_BITS-1:0] total_q, total_d, first_cnt_q, first_cnt_d;
  logic [srmj_pkg::COUNT_BITS-1:0] second_cnt_q, second_cnt_d, matched_q, matched_d;

  srmj_pkg::need_side_t need;
  logic                 take;
  logic [KEY_BITS-1:0]  first_key, second_key;
  logic                 pick_first, pick_second, pick_both;

  // Decode the request and load the beat into its head
  always_comb begin
    need = srmj_pkg::wanted_side(first_q, second_q);
    take = accept_i && (need != srmj_pkg::NEED_FINISHED) &&
           ((need == srmj_pkg::NEED_EITHER) || (need == {1'b0, side_i}));

    first_ld       = first_q;
    second_ld      = second_q;
    first_chrom_d  = first_chrom_q;
    first_locus_d  = first_locus_q;
    first_value_d  = first_value_q;
    second_chrom_d = second_chrom_q;
    second_locus_d = second_locus_q;
    second_value_d = second_value_q;
    if (take) begin
      if (end_of_side_i) begin
        if (!side_i) first_ld.finished = 1'b1;
        else second_ld.finished = 1'b1;
      end else if (!side_i) begin
        first_ld.head_valid = 1'b1;
        first_chrom_d       = chrom_i;
        first_locus_d       = locus_i;
        first_value_d       = read_value_i;
      end else begin
        second_ld.head_valid = 1'b1;
        second_chrom_d       = chrom_i;
        second_locus_d       = locus_i;
        second_value_d       = read_value_i;
      end
    end
  end

  // Compare the heads and pick the row to emit
  always_comb begin
    first_key   = {first_chrom_d, first_locus_d};
    second_key  = {second_chrom_d, second_locus_d};
    pick_first  = 1'b0;
    pick_second = 1'b0;
    pick_both   = 1'b0;
    if (first_ld.head_valid && second_ld.head_valid) begin
      if (first_key < second_key) pick_first = 1'b1;
      else if (first_key > second_key) pick_second = 1'b1;
      else pick_both = 1'b1;
    end else if (first_ld.head_valid && second_ld.finished) begin
      pick_first = 1'b1;
    end else if (second_ld.head_valid && first_ld.finished) begin
      pick_second = 1'b1;
    end
  end

  // Drop consumed heads, advance counters and build the result beat
  always_comb begin
    first_d      = first_ld;
    second_d     = second_ld;
    total_d      = total_q;
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    matched_d    = matched_q;

    row_valid_o        = 1'b0;
    row_chrom_o        = '0;
    row_locus_o        = '0;
    row_first_value_o  = '0;
    row_second_value_o = '0;
    row_kind_o         = srmj_pkg::KIND_FIRST;

    if (pick_first || pick_both) begin
      first_d.head_valid = 1'b0;
      row_first_value_o  = first_value_d;
    end
    if (pick_second || pick_both) begin
      second_d.head_valid = 1'b0;
      row_second_value_o  = second_value_d;
    end
    if (pick_first) begin
      first_cnt_d = srmj_pkg::sat_inc(first_cnt_q);
      row_kind_o  = srmj_pkg::KIND_FIRST;
    end else if (pick_second) begin
      second_cnt_d = srmj_pkg::sat_inc(second_cnt_q);
      row_kind_o   = srmj_pkg::KIND_SECOND;
    end else if (pick_both) begin
      matched_d  = srmj_pkg::sat_inc(matched_q);
      row_kind_o = srmj_pkg::KIND_BOTH;
    end
    if (pick_first || pick_second || pick_both) begin
      total_d     = srmj_pkg::sat_inc(total_q);
      row_valid_o = 1'b1;
      row_chrom_o = pick_second ? second_chrom_d : first_chrom_d;
      row_locus_o = pick_second ? second_locus_d : first_locus_d;
    end

    total_rows_o       = total_d;
    first_only_rows_o  = first_cnt_d;
    second_only_rows_o = second_cnt_d;
    matched_rows_o     = matched_d;
    need_side_o        = srmj_pkg::wanted_side(first_d, second_d);
  end

  // Hold control state and counters; update only on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= '0;
      second_q     <= '0;
      total_q      <= '0;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      matched_q    <= '0;
    end else if (accept_i) begin
      first_q      <= first_d;
      second_q     <= second_d;
      total_q      <= total_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      matched_q    <= matched_d;
    end
  end

  // Head payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      first_chrom_q  <= first_chrom_d;
      first_locus_q  <= first_locus_d;
      first_value_q  <= first_value_d;
      second_chrom_q <= second_chrom_d;
      second_locus_q <= second_locus_d;
      second_value_q <= second_value_d;
    end
  end

endmodule

/* sv/srmj_out_reg.sv */
// Result register of the merge join: holds one result beat until taken.
// Depends on srmj_pkg for counter width and code types.
`timescale 1ns / 1ps

module srmj_out_reg #(
  parameter int CHROM_BITS = 8,
  parameter int LOCUS_BITS = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic                            stall_i,
  output logic                            busy_o,
  input  logic                            row_valid_i,
  input  logic [CHROM_BITS-1:0]           row_chrom_i,
  input  logic [LOCUS_BITS-1:0]           row_locus_i,
  input  logic [VALUE_BITS-1:0]           row_first_value_i,
  input  logic [VALUE_BITS-1:0]           row_second_value_i,
  input  srmj_pkg::row_kind_t             row_kind_i,
  input  logic [srmj_pkg::COUNT_BITS-1:0] total_rows_i,
  input  logic [srmj_pkg::COUNT_BITS-1:0] first_only_rows_i,
  input  logic [srmj_pkg::COUNT_BITS-1:0] second_only_rows_i,
  input  logic [srmj_pkg::COUNT_BITS-1:0] matched_rows_i,
  input  srmj_pkg::need_side_t            need_side_i,
  output logic                            valid_o,
  output logic                            row_valid_o,
  output logic [CHROM_BITS-1:0]           row_chrom_o,
  output logic [LOCUS_BITS-1:0]           row_locus_o,
  output logic [VALUE_BITS-1:0]           row_first_value_o,
  output logic [VALUE_BITS-1:0]           row_second_value_o,
  output srmj_pkg::row_kind_t             row_kind_o,
  output logic [srmj_pkg::COUNT_BITS-1:0] total_rows_o,
  output logic [srmj_pkg::COUNT_BITS-1:0] first_only_rows_o,
  output logic [srmj_pkg::COUNT_BITS-1:0] second_only_rows_o,
  output logic [srmj_pkg::COUNT_BITS-1:0] matched_rows_o,
  output srmj_pkg::need_side_t            need_side_o
);

  logic valid_q;

  // Full while a beat waits on a stalled consumer
  assign busy_o  = valid_q && stall_i;
  assign valid_o = valid_q;

  // Track occupancy: fill on load, empty when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      row_valid_o        <= row_valid_i;
      row_chrom_o        <= row_chrom_i;
      row_locus_o        <= row_locus_i;
      row_first_value_o  <= row_first_value_i;
      row_second_value_o <= row_second_value_i;
      row_kind_o         <= row_kind_i;
      total_rows_o       <= total_rows_i;
      first_only_rows_o  <= first_only_rows_i;
      second_only_rows_o <= second_only_rows_i;
      matched_rows_o     <= matched_rows_i;
      need_side_o        <= need_side_i;
    end
  end

endmodule

/* sv/sorted_record_merge_join_unit.sv */
// Top level of the two-way sorted merge with full outer join.
// Depends on srmj_pkg, srmj_core and srmj_out_reg.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------------
//   input   | in_valid_i / in_stall_o | side, end_of_side, chrom, locus, read_value
//   output  | out_valid_o / out_stall_i | row fields, four counters, need_side
//
// One record beat is accepted per cycle while the input is not stalled; its result
// beat appears in the result register on the next cycle, through the single
// compare/update path from heads to result register.
// Reset clears head valid bits, end flags, counters and the result register's valid flag.
// The input stalls only while a result beat is held and the output is stalled.
`timescale 1ns / 1ps

module sorted_record_merge_join_unit #(
  parameter int CHROM_BITS = 8,
  parameter int LOCUS_BITS = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            side_i,
  input  logic                            end_of_side_i,
  input  logic [CHROM_BITS-1:0]           chrom_i,
  input  logic [LOCUS_BITS-1:0]           locus_i,
  input  logic [VALUE_BITS-1:0]           read_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            row_valid_o,
  output logic [CHROM_BITS-1:0]           row_chrom_o,
  output logic [LOCUS_BITS-1:0]           row_locus_o,
  output logic [VALUE_BITS-1:0]           row_first_value_o,
  output logic [VALUE_BITS-1:0]           row_second_value_o,
  output logic [1:0]                      row_kind_o,
  output logic [srmj_pkg::COUNT_BITS-1:0] total_rows_o,
  output logic [srmj_pkg::COUNT_BITS-1:0] first_only_rows_o,
  output logic [srmj_pkg::COUNT_BITS-1:0] second_only_rows_o,
  output logic [srmj_pkg::COUNT_BITS-1:0] matched_rows_o,
  output logic [1:0]                      need_side_o
);

  logic                            accept;
  logic                            nx_row_valid;
  logic [CHROM_BITS-1:0]           nx_chrom;
  logic [LOCUS_BITS-1:0]           nx_locus;
  logic [VALUE_BITS-1:0]           nx_first_value;
  logic [VALUE_BITS-1:0]           nx_second_value;
  srmj_pkg::row_kind_t             nx_kind;
  logic [srmj_pkg::COUNT_BITS-1:0] nx_total;
  logic [srmj_pkg::COUNT_BITS-1:0] nx_first_only;
  logic [srmj_pkg::COUNT_BITS-1:0] nx_second_only;
  logic [srmj_pkg::COUNT_BITS-1:0] nx_matched;
  srmj_pkg::need_side_t            nx_need;

  // Accept a record beat whenever the result register can take its result
  assign accept = in_valid_i && !in_stall_o;

  srmj_core #(
    .CHROM_BITS(CHROM_BITS),
    .LOCUS_BITS(LOCUS_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .side_i             (side_i),
    .end_of_side_i      (end_of_side_i),
    .chrom_i            (chrom_i),
    .locus_i            (locus_i),
    .read_value_i       (read_value_i),
    .row_valid_o        (nx_row_valid),
    .row_chrom_o        (nx_chrom),
    .row_locus_o        (nx_locus),
    .row_first_value_o  (nx_first_value),
    .row_second_value_o (nx_second_value),
    .row_kind_o         (nx_kind),
    .total_rows_o       (nx_total),
    .first_only_rows_o  (nx_first_only),
    .second_only_rows_o (nx_second_only),
    .matched_rows_o     (nx_matched),
    .need_side_o        (nx_need)
  );

  srmj_out_reg #(
    .CHROM_BITS(CHROM_BITS),
    .LOCUS_BITS(LOCUS_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_out_reg (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (accept),
    .stall_i            (out_stall_i),
    .busy_o             (in_stall_o),
    .row_valid_i        (nx_row_valid),
    .row_chrom_i        (nx_chrom),
    .row_locus_i        (nx_locus),
    .row_first_value_i  (nx_first_value),
    .row_second_value_i (nx_second_value),
    .row_kind_i         (nx_kind),
    .total_rows_i       (nx_total),
    .first_only_rows_i  (nx_first_only),
    .second_only_rows_i (nx_second_only),
    .matched_rows_i     (nx_matched),
    .need_side_i        (nx_need),
    .valid_o            (out_valid_o),
    .row_valid_o        (row_valid_o),
    .row_chrom_o        (row_chrom_o),
    .row_locus_o        (row_locus_o),
    .row_first_value_o  (row_first_value_o),
    .row_second_value_o (row_second_value_o),
    .row_kind_o         (row_kind_o),
    .total_rows_o       (total_rows_o),
    .first_only_rows_o  (first_only_rows_o),
    .second_only_rows_o (second_only_rows_o),
    .matched_rows_o     (matched_rows_o),
    .need_side_o        (need_side_o)
  );

endmodule
